[design/hashlp_pkg.sv]
`timescale 1ns / 1ps

package hashlp_pkg;

   // Defaults for the top-level parameters.
   localparam int TABLE_BITS_DEF = 12;
   localparam int INDEX_BITS_DEF = 16;

   // Field widths of the items.
   localparam int OP_W     = 2;
   localparam int KEY_W    = 32;
   localparam int REC_W    = 16;
   localparam int STATUS_W = 3;
   localparam int FOUND_W  = 16;
   localparam int SIZE_W   = 4;

   // Result payload, padded to whole bytes.
   localparam int RSP_W = ((STATUS_W + FOUND_W + 7) / 8) * 8;

   // Size register: reset value and smallest usable table.
   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd12;
   localparam int SIZE_MIN = 4;

   // Fibonacci hashing multiplier.
   localparam logic [KEY_W-1:0] HASH_MULT = 32'h9E37_79B1;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_INSERT = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 3'd0,
      ST_DUP  = 3'd1,
      ST_ZERO = 3'd2,
      ST_MISS = 3'd3,
      ST_FULL = 3'd4
   } status_type;

endpackage

[design/hashlp_ram.sv]
`timescale 1ns / 1ps

module hashlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/hash_table_linear_probe.sv]
`timescale 1ns / 1ps

// Open-addressing hash table with linear probing that maps a 32-bit key to a
// record index. The home slot of a key is the low size_log2 bits of the key
// times 0x9E3779B1, and probing steps one slot at a time with wrap-around
// inside the 2^size_log2 slots in use (size_log2 is clamped to 4..TABLE_BITS).
// All slots live in one single-port-read, single-port-write synchronous RAM
// of 2^TABLE_BITS entries, each holding a valid bit, the key and the index.
// After reset the block sweeps the RAM once to clear the valid bits; a clear
// request does the same sweep and then answers. An insert or lookup passes
// through a hash step, one RAM read per probed slot, a step that hands the
// result on, and an idle state in which the next item is accepted; the block
// takes no new item before it is through with the last one. An insert or
// lookup of key zero and the unused op code answer without touching the RAM.
// A lookup or insert of an absent key in a full table probes every slot in
// use and answers "not found" or "table full". The next item is accepted
// while an earlier result still waits in the output register. The user
// must write configuration (size_log2) only while idle; the block itself
// does not enforce it.

module hash_table_linear_probe #(
   parameter int TABLE_BITS = hashlp_pkg::TABLE_BITS_DEF,
   parameter int INDEX_BITS = hashlp_pkg::INDEX_BITS_DEF
) (
   input  logic                                         clock,
   input  logic                                         reset,
   // Request item.
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // tdata, from bit 0: key (32), record_index (16).
   input  logic [hashlp_pkg::KEY_W+hashlp_pkg::REC_W-1:0] req_tdata,
   // tuser, from bit 0: op (2).
   input  logic [hashlp_pkg::OP_W-1:0]                  req_tuser,
   // Result item.
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // tdata, from bit 0: status (3), found_index (16), zero padding.
   output logic [hashlp_pkg::RSP_W-1:0]                 rsp_tdata,
   // Configuration write: size_log2.
   input  logic                                         csr_valid,
   output logic                                         csr_ready,
   input  logic [hashlp_pkg::SIZE_W-1:0]                csr_data
);

   import hashlp_pkg::*;

   // Stored index width: the record field never carries more than REC_W bits.
   localparam int IDX_W   = (INDEX_BITS < REC_W) ? INDEX_BITS : REC_W;
   localparam int ENTRY_W = 1 + KEY_W + IDX_W;
   localparam int DEPTH   = 1 << TABLE_BITS;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_HASH  = 5'b00010,
      S_CHECK = 5'b00100,
      S_CLEAR = 5'b01000,
      S_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [TABLE_BITS-1:0] mask;

   // Item being worked on.
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [IDX_W-1:0]  rec_ff, rec_in;
   logic              is_insert_ff, is_insert_in;

   // Probe position and number of slots already passed.
   logic [TABLE_BITS-1:0] pos_ff, pos_in;
   logic [TABLE_BITS-1:0] count_ff, count_in;
   logic [TABLE_BITS-1:0] pos_next;

   // Clearing sweep.
   logic [TABLE_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic                  clr_reply_ff, clr_reply_in;

   // Finished result waiting for the output register.
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [FOUND_W-1:0]  res_found_ff, res_found_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [FOUND_W-1:0]  rsp_found_ff, rsp_found_in;

   // RAM ports.
   logic                  wr_en;
   logic [TABLE_BITS-1:0] wr_addr;
   logic [ENTRY_W-1:0]    wr_data;
   logic [TABLE_BITS-1:0] rd_addr;
   logic [ENTRY_W-1:0]    rd_data;

   logic                  rd_valid;
   logic [KEY_W-1:0]      rd_key;
   logic [IDX_W-1:0]      rd_idx;
   logic [KEY_W-1:0]      hash_prod;
   logic                  req_accept;
   logic                  out_free;
   op_type                req_op;
   logic [KEY_W-1:0]      req_key;
   logic [REC_W-1:0]      req_rec;

   hashlp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_valid = rd_data[ENTRY_W-1];
   assign rd_key   = rd_data[IDX_W +: KEY_W];
   assign rd_idx   = rd_data[IDX_W-1:0];

   // A slot bit is in use when it lies below the clamped size. The upper clamp
   // at TABLE_BITS falls out of the mask width.
   always_comb begin
      for (int i = 0; i < TABLE_BITS; i++) begin
         mask[i] = (i < SIZE_MIN) || (i < int'(size_ff));
      end
   end

   assign hash_prod = key_ff * HASH_MULT;
   assign pos_next  = (pos_ff + 1'b1) & mask;

   assign req_op     = op_type'(req_tuser);
   assign req_key    = req_tdata[KEY_W-1:0];
   assign req_rec    = req_tdata[KEY_W +: REC_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign csr_ready = 1'b1;
   assign size_in   = (csr_valid && csr_ready) ? csr_data : size_ff;

   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      rec_in        = rec_ff;
      is_insert_in  = is_insert_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_reply_in  = clr_reply_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      rd_addr       = pos_ff;
      wr_en         = 1'b0;
      wr_addr       = pos_ff;
      wr_data       = {1'b1, key_ff, rec_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               key_in        = req_key;
               rec_in        = IDX_W'(req_rec);
               is_insert_in  = (req_op == OP_INSERT);
               res_found_in  = '0;
               res_status_in = ST_OK;
               case (req_op)
                  OP_CLEAR: begin
                     clr_cnt_in   = '0;
                     clr_reply_in = 1'b1;
                     state_in     = S_CLEAR;
                  end
                  OP_INSERT: begin
                     if (req_key == '0) begin
                        res_status_in = ST_ZERO;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_HASH;
                     end
                  end
                  OP_LOOKUP: begin
                     if (req_key == '0) begin
                        res_status_in = ST_MISS;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_HASH;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_HASH: begin
            // Read the home slot; its data is there in the next cycle.
            pos_in   = hash_prod[TABLE_BITS-1:0] & mask;
            rd_addr  = pos_in;
            count_in = '0;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!rd_valid) begin
               // Empty slot ends the probe: the key is absent.
               if (is_insert_ff) begin
                  wr_en         = 1'b1;
                  res_status_in = ST_OK;
               end else begin
                  res_status_in = ST_MISS;
               end
               state_in = S_DONE;
            end else if (rd_key == key_ff) begin
               res_status_in = is_insert_ff ? ST_DUP : ST_OK;
               res_found_in  = FOUND_W'(rd_idx);
               state_in      = S_DONE;
            end else if (count_ff == mask) begin
               // Every slot in use has been probed.
               res_status_in = is_insert_ff ? ST_FULL : ST_MISS;
               state_in      = S_DONE;
            end else begin
               // Read the next slot while this one is being checked.
               pos_in   = pos_next;
               rd_addr  = pos_next;
               count_in = count_ff + 1'b1;
            end
         end
         S_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               state_in     = clr_reply_ff ? S_DONE : S_IDLE;
               clr_reply_in = 1'b0;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register takes the result as soon as it is free.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      if ((state_ff == S_DONE) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_found_in  = res_found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // The sweep after reset clears every valid bit before the first item.
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         clr_reply_ff <= 1'b0;
         size_ff      <= SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_reply_ff <= clr_reply_in;
         size_ff      <= size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      rec_ff        <= rec_in;
      is_insert_ff  <= is_insert_in;
      pos_ff        <= pos_in;
      count_ff      <= count_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({rsp_found_ff, rsp_status_ff});

endmodule
